[rtl/pcpa_pkg.sv]
// ----------------------------------------------------------------------------
// pcpa_pkg: shared types and constants for the per-CPU page allocator
// Opcodes, status codes and default sizes used by the top level and its parts.
// ----------------------------------------------------------------------------
package pcpa_pkg;
    localparam int ADDR_W         = 39;
    localparam int PAGE_SHIFT     = 12;
    localparam int DEF_NUM_CPUS   = 8;
    localparam int DEF_NUM_PAGES  = 32768;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam int CFG_BASE = 0;
    localparam int CFG_TOP  = 1;
endpackage

[rtl/per_cpu_page_allocator_steal_top.sv]
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_steal_top: per-CPU free page lists with stealing
// LIFO free list of 4 KiB pages per CPU in a link memory with per-CPU heads.
// ----------------------------------------------------------------------------
// A request is one transfer in and gives exactly one result transfer. A free
// passes through the head check and the result state; an alloc from a nonempty
// list does the head check and then waits in S_POPW for the registered link
// memory read. An alloc that finds its list empty walks the other CPUs in ring
// order through S_STEAL and S_STW for each, then pops. Init clears all heads and
// pushes every page in each CPU's slice, one page per cycle, with a slice setup
// step per CPU. One request is worked on at a time; the next request is taken in
// the cycle after the previous result has been taken.
module per_cpu_page_allocator_steal_top #(
    parameter int NUM_CPUS  = pcpa_pkg::DEF_NUM_CPUS,
    parameter int NUM_PAGES = pcpa_pkg::DEF_NUM_PAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [pcpa_pkg::ADDR_W-1:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: opcode[1:0], cpu[4:2], page_address[43:5], zero fill [47:44]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: alloc_address[38:0], status[40:39], pages_stolen[43:41], zero [47:44]
    output logic [47:0] m_axis_tdata
);
    import pcpa_pkg::*;

    localparam int AW  = $clog2(NUM_PAGES);
    localparam int DW  = $clog2(NUM_PAGES + 1);
    localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int PW  = ADDR_W - PAGE_SHIFT;
    localparam logic [DW-1:0] NULLM = DW'(NUM_PAGES);
    localparam logic [2:0] S_IDLE = 3'd0, S_POP = 3'd1, S_POPW = 3'd2,
        S_STEAL = 3'd3, S_STW = 3'd4, S_ISET = 3'd5, S_IRUN = 3'd6, S_OUT = 3'd7;

    logic [ADDR_W-1:0] r_base, r_top;
    logic [DW-1:0] r_head [NUM_CPUS];
    logic [2:0]    r_state;
    logic [1:0]    r_op;
    logic          r_retry;
    logic [CW-1:0] r_cpu, r_vic;
    logic [ADDR_W-1:0] r_pa;
    logic [CW:0]   r_cnt;
    logic [2:0]    r_stolen;
    logic [DW-1:0] r_got;
    logic [ADDR_W-1:0] r_res_addr;
    logic [1:0]    r_res_st;
    logic          r_out_v;
    // init walk
    logic [PW:0]   r_ip;
    logic [ADDR_W-1:0] r_sstart;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    pcpa_link_ram #(.DEPTH(NUM_PAGES), .AW(AW), .DW(DW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [PW:0] fp;
    assign fp = (PW+1)'(({1'b0, r_base} + (ADDR_W+1)'(4095)) >> PAGE_SHIFT);

    logic [1:0]    in_op;
    logic [CW-1:0] in_cpu;
    assign in_op = s_axis_tdata[1:0];
    assign in_cpu = CW'(32'(s_axis_tdata[4:2]) % NUM_CPUS);

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_v;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = {4'd0, r_stolen, r_res_st, r_res_addr};

    // free checks
    logic [PW:0] fidx;
    logic        fbad;
    assign fidx = (PW+1)'(r_pa >> PAGE_SHIFT) - fp;
    assign fbad = (r_pa[PAGE_SHIFT-1:0] != '0) || (r_pa < r_base) || (r_pa >= r_top)
        || (fidx >= (PW+1)'(NUM_PAGES));

    logic [DW-1:0] h_cpu, h_vic;
    assign h_cpu = r_head[r_cpu];
    assign h_vic = r_head[r_vic];
    logic [CW-1:0] vic_nx;
    assign vic_nx = (32'(r_vic) + 1 >= NUM_CPUS) ? '0 : CW'(32'(r_vic) + 1);

    // init slice geometry for CPU r_vic; the slice start advances by one slice per CPU
    logic [ADDR_W-1:0] span, slice, sstop;
    assign span  = r_top - r_base;
    assign slice = span / ADDR_W'(NUM_CPUS);
    assign sstop = (32'(r_vic) == NUM_CPUS - 1) ? r_top :
        (slice == '0) ? r_sstart : r_sstart + slice - ADDR_W'(1);
    logic [ADDR_W:0] ip_end;
    assign ip_end = {r_ip, {PAGE_SHIFT{1'b0}}} + (ADDR_W+1)'(4096);

    always_comb begin
        raddr = AW'(h_cpu);
        if (r_state == S_STW && r_got < NULLM) begin
            raddr = AW'(h_vic);
        end
        if (r_state == S_STEAL) raddr = AW'(h_vic);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= ADDR_W'(64'h80000000);
            r_top  <= ADDR_W'(64'h88000000);
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            for (int c = 0; c < NUM_CPUS; c++) r_head[c] <= NULLM;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == 1'(CFG_BASE)) r_base <= i_cfg_wdata;
                else r_top <= i_cfg_wdata;
            end
            if (r_out_v && m_axis_tready) r_out_v <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_op <= in_op;
                    r_retry <= 1'b0;
                    r_cpu <= in_cpu;
                    r_pa <= s_axis_tdata[43:5];
                    r_stolen <= '0;
                    r_res_addr <= '0;
                    r_res_st <= ST_OK;
                    r_state <= S_POP;
                end
                S_POP: begin
                    // After the steal walk the pop is tried once more.
                    if (r_retry) begin
                        if (h_cpu < NULLM) begin
                            r_got <= h_cpu;
                            r_state <= S_POPW;
                        end else begin
                            r_res_st <= ST_OOM;
                            r_state <= S_OUT;
                        end
                    end else if (r_op == OP_ALLOC) begin
                        if (h_cpu < NULLM) begin
                            r_got <= h_cpu;
                            r_state <= S_POPW;
                        end else if (NUM_CPUS > 1) begin
                            r_vic <= (32'(r_cpu) + 1 >= NUM_CPUS) ? '0 : CW'(32'(r_cpu) + 1);
                            r_cnt <= '0;
                            r_state <= S_STEAL;
                        end else begin
                            r_res_st <= ST_OOM;
                            r_state <= S_OUT;
                        end
                    end else if (r_op == OP_FREE) begin
                        if (fbad) r_res_st <= ST_BAD;
                        else begin
                            r_head[r_cpu] <= DW'(fidx);
                        end
                        r_state <= S_OUT;
                    end else if (r_op == OP_INIT) begin
                        for (int c = 0; c < NUM_CPUS; c++) r_head[c] <= NULLM;
                        r_vic <= '0;
                        r_sstart <= r_base;
                        r_state <= (r_top <= r_base) ? S_OUT : S_ISET;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_POPW: begin
                    r_head[r_cpu] <= rdata < NULLM ? rdata : NULLM;
                    r_res_addr <= ADDR_W'((fp + (PW+1)'(r_got)) << PAGE_SHIFT);
                    r_state <= S_OUT;
                end
                S_STEAL: begin
                    r_got <= h_vic;
                    r_state <= S_STW;
                end
                S_STW: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_got < NULLM) begin
                        r_head[r_vic] <= rdata < NULLM ? rdata : NULLM;
                        r_head[r_cpu] <= r_got;
                        if (r_stolen != 3'd7) r_stolen <= r_stolen + 1'b1;
                    end
                    r_vic <= vic_nx;
                    if (32'(r_cnt) + 2 >= NUM_CPUS) begin
                        r_retry <= 1'b1;
                        r_state <= S_POP;
                    end else begin
                        r_state <= S_STEAL;
                    end
                end
                S_ISET: begin
                    r_ip <= (PW+1)'(({1'b0, r_sstart} + (ADDR_W+1)'(4095)) >> PAGE_SHIFT);
                    r_state <= S_IRUN;
                end
                S_IRUN: begin
                    if (ip_end <= {1'b0, sstop} && (r_ip - fp) < (PW+1)'(NUM_PAGES)) begin
                        r_head[r_vic] <= DW'(r_ip - fp);
                        r_ip <= r_ip + 1'b1;
                    end else if (32'(r_vic) == NUM_CPUS - 1) begin
                        r_state <= S_OUT;
                    end else begin
                        r_vic <= r_vic + 1'b1;
                        r_sstart <= r_sstart + slice;
                        r_state <= S_ISET;
                    end
                end
                S_OUT: begin
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // link memory writes, registered-free combinational port usage
    always_comb begin : wr
        if (r_state == S_POP && !r_retry && r_op == OP_FREE && !fbad) begin
            we = 1'b1; waddr = AW'(fidx); wdata = h_cpu;
        end else if (r_state == S_STW && r_got < NULLM) begin
            we = 1'b1; waddr = AW'(r_got); wdata = h_cpu;
        end else if (r_state == S_IRUN && ip_end <= {1'b0, sstop}
                     && (r_ip - fp) < (PW+1)'(NUM_PAGES)) begin
            we = 1'b1; waddr = AW'(r_ip - fp); wdata = h_vic;
        end else begin
            we = 1'b0; waddr = '0; wdata = '0;
        end
    end
endmodule

[rtl/pcpa_link_ram.sv]
// ----------------------------------------------------------------------------
// pcpa_link_ram: next-link memory over page indices
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module pcpa_link_ram #(
    parameter int DEPTH = pcpa_pkg::DEF_NUM_PAGES,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/pcpa_checker.sv]
// ----------------------------------------------------------------------------
// pcpa_checker: port-level checks for the page allocator
// Watches the stream ports and the result fields over time.
// ----------------------------------------------------------------------------
module pcpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    import pcpa_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
    a_oom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[40:39] != ST_OK |-> m_axis_tdata[38:0] == '0)
        else $error("address given with failing status");
    a_steal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[40:39] == ST_BAD |-> m_axis_tdata[43:41] == '0)
        else $error("stolen pages reported on a free");
endmodule

bind per_cpu_page_allocator_steal_top pcpa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
